@@ sv/indexed_deque_engine_core_macros.svh @@
// Assertion macros for the RTL files; only the sequencer includes them.
// Simulation builds get concurrent assertions. Synthesis builds define SYNTH and get nothing.
`ifndef INDEXED_DEQUE_ENGINE_CORE_MACROS_SVH
`define INDEXED_DEQUE_ENGINE_CORE_MACROS_SVH

`ifndef SYNTH

// The property must hold at every rising clock edge outside reset.
`define IDE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// The condition must never be seen at a rising clock edge outside reset.
`define IDE_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define IDE_ASSERT(lbl, clk, rstn, prop, msg)
`define IDE_ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

@@ sv/deq_pkg.sv @@
package deq_pkg;

  // Default sizing of the entry store.
  localparam int unsigned DEFAULT_CAPACITY   = 256;
  localparam int unsigned DEFAULT_DATA_WIDTH = 32;

  // Fixed widths of the channel fields.
  localparam int unsigned KIND_W   = 4;
  localparam int unsigned POS_W    = 9;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 9;

  // Operation codes carried in the kind field.
  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 4'd0,
    KIND_PUSH_BACK  = 4'd1,
    KIND_POP_FRONT  = 4'd2,
    KIND_POP_BACK   = 4'd3,
    KIND_PEEK_FRONT = 4'd4,
    KIND_PEEK_BACK  = 4'd5,
    KIND_INSERT_AT  = 4'd6,
    KIND_REMOVE_AT  = 4'd7,
    KIND_REPLACE_AT = 4'd8,
    KIND_READ_AT    = 4'd9,
    KIND_CLEAR      = 4'd10
  } deq_kind_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_EMPTY  = 2'd1,
    STATUS_FULL   = 2'd2,
    STATUS_BADPOS = 2'd3
  } deq_status_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_RM_CAP,
    S_SHIFT,
    S_FILL,
    S_DONE
  } deq_state_e;

  // One result item as handed from the sequencer to the output register.
  typedef struct packed {
    logic [VALUE_W-1:0]  data;
    deq_status_e         status;
    logic [COUNT_W-1:0]  count;
  } deq_result_t;

endpackage

@@ sv/deq_if.sv @@
// Operation channel: one transfer carries one operation.
interface deq_in_if;
  logic                                valid;
  logic                                ready;
  logic [deq_pkg::KIND_W-1:0]          kind;
  logic [deq_pkg::POS_W-1:0]           position;
  logic signed [deq_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output kind, output position, output value, input ready);
  modport sink   (input valid, input kind, input position, input value, output ready);
endinterface

// Result channel: one transfer carries one result.
interface deq_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [deq_pkg::VALUE_W-1:0]  data;
  logic [deq_pkg::STATUS_W-1:0]        status;
  logic [deq_pkg::COUNT_W-1:0]         count;

  modport source (output valid, output data, output status, output count, input ready);
  modport sink   (input valid, input data, input status, input count, output ready);
endinterface

@@ sv/indexed_deque_engine_core.sv @@
// Bounded deque with positional access, kept as a circular list in a single-port-pair
// memory (one read and one write per cycle). Each operation on the input channel gives
// exactly one result: the word read, removed or overwritten, a status (ok, empty, full
// or bad position, with nothing changed on error) and the count afterwards. Push, pop,
// peek, read, replace, clear and every error go from transfer straight to the result.
// Insert and remove at position p take longer, since the entries between p and the rear
// move one memory slot per cycle through the read-then-write loop of the entry store.
// An insert at the end is a plain append. The next operation is taken in the cycle after
// a result has moved into the output register, which holds it until the sink takes it.
// The store needs no initialisation after reset.
module indexed_deque_engine_core #(
  parameter int unsigned CAPACITY   = deq_pkg::DEFAULT_CAPACITY,
  parameter int unsigned DATA_WIDTH = deq_pkg::DEFAULT_DATA_WIDTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  deq_in_if.sink    in_i,
  deq_out_if.source out_o
);

  localparam int unsigned AddrW = $clog2(CAPACITY);

  logic                  res_valid;
  logic                  res_ready;
  deq_pkg::deq_result_t  res;
  logic                  mem_re;
  logic [AddrW-1:0]      mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;
  logic                  mem_we;
  logic [AddrW-1:0]      mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;

  // Operation sequencer.
  deq_ctrl #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata)
  );

  // Entry store.
  deq_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_WIDTH)
  ) u_mem (
    .clk_i   (clk_i),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata)
  );

  // Result register towards the sink.
  deq_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .res_ready_o (res_ready),
    .out_o       (out_o)
  );

endmodule

@@ sv/deq_mem.sv @@
// Entry store: one write port and one read port, read data registered.
module deq_mem #(
  parameter  int unsigned DEPTH = deq_pkg::DEFAULT_CAPACITY,
  parameter  int unsigned WIDTH = deq_pkg::DEFAULT_DATA_WIDTH,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // A read at the address being written returns the old word.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/deq_out_reg.sv @@
// Output register: holds one finished result until the sink takes it.
module deq_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 res_valid_i,
  input  deq_pkg::deq_result_t res_i,
  output logic                 res_ready_o,
  deq_out_if.source            out_o
);

  logic                 valid_q;
  deq_pkg::deq_result_t res_q;

  // The slot frees up in the same cycle as the sink takes its result.
  assign res_ready_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_ready_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i && res_ready_o) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid  = valid_q;
  assign out_o.data   = res_q.data;
  assign out_o.status = res_q.status;
  assign out_o.count  = res_q.count;

endmodule

@@ sv/deq_ctrl.sv @@
// Sequencer: decodes an operation, keeps front index and count, drives the
// entry store and walks it one entry per cycle for positional insert and remove.
module deq_ctrl #(
  parameter  int unsigned CAPACITY   = deq_pkg::DEFAULT_CAPACITY,
  parameter  int unsigned DATA_WIDTH = deq_pkg::DEFAULT_DATA_WIDTH,
  localparam int unsigned AddrW      = $clog2(CAPACITY),
  localparam int unsigned CntW       = $clog2(CAPACITY + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  deq_in_if.sink                in_i,
  output logic                  res_valid_o,
  output deq_pkg::deq_result_t  res_o,
  input  logic                  res_ready_i,
  output logic                  mem_re_o,
  output logic [AddrW-1:0]      mem_raddr_o,
  input  logic [DATA_WIDTH-1:0] mem_rdata_i,
  output logic                  mem_we_o,
  output logic [AddrW-1:0]      mem_waddr_o,
  output logic [DATA_WIDTH-1:0] mem_wdata_o
);

  `include "indexed_deque_engine_core_macros.svh"

  // Position arithmetic is done wide enough for both the field and the count.
  localparam int unsigned PosW = (CntW > deq_pkg::POS_W) ? CntW : deq_pkg::POS_W;
  localparam int unsigned SumW = PosW + 1;

  deq_pkg::deq_state_e  state_q, state_d;
  logic [AddrW-1:0]     front_q, front_d;
  logic [CntW-1:0]      count_q, count_d;
  logic [CntW-1:0]      moves_q, moves_d;
  logic [AddrW-1:0]     rd_slot_q, rd_slot_d;
  logic [AddrW-1:0]     wr_slot_q, wr_slot_d;
  logic [DATA_WIDTH-1:0] val_q, val_d;
  logic [deq_pkg::VALUE_W-1:0] res_data_q, res_data_d;
  logic                 from_mem_q, from_mem_d;
  logic                 insert_q, insert_d;
  deq_pkg::deq_status_e status_q, status_d;

  logic                 accept;
  deq_pkg::deq_kind_e   kind;
  logic                 is_full;
  logic                 is_empty;
  logic [PosW-1:0]      pos_ext;
  logic [PosW-1:0]      cnt_ext;
  logic                 pos_gt_cnt;
  logic                 pos_ge_cnt;
  logic [PosW-1:0]      lidx;
  logic [SumW-1:0]      slot_sum;
  logic [AddrW-1:0]     slot;
  logic [DATA_WIDTH-1:0] in_val;

  // Circular slot step forward.
  function automatic logic [AddrW-1:0] slot_inc(input logic [AddrW-1:0] x);
    return (x == AddrW'(CAPACITY - 1)) ? '0 : x + 1'b1;
  endfunction

  // Circular slot step backward.
  function automatic logic [AddrW-1:0] slot_dec(input logic [AddrW-1:0] x);
    return (x == '0) ? AddrW'(CAPACITY - 1) : x - 1'b1;
  endfunction

  // A stored word is sign extended from the entry width to the result field.
  function automatic logic [deq_pkg::VALUE_W-1:0] widen(input logic [DATA_WIDTH-1:0] w);
    logic signed [63:0] x;
    x = 64'(signed'(w));
    return x[deq_pkg::VALUE_W-1:0];
  endfunction

  // Operations are taken one at a time while the sequencer is idle.
  assign in_i.ready = (state_q == deq_pkg::S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign kind       = deq_pkg::deq_kind_e'(in_i.kind);

  assign is_full    = (count_q == CntW'(CAPACITY));
  assign is_empty   = (count_q == '0);
  assign pos_ext    = PosW'(in_i.position);
  assign cnt_ext    = PosW'(count_q);
  assign pos_gt_cnt = (pos_ext > cnt_ext);
  assign pos_ge_cnt = (pos_ext >= cnt_ext);
  assign in_val     = DATA_WIDTH'(64'(in_i.value));

  // Logical position whose slot this operation touches first.
  always_comb begin
    case (kind)
      deq_pkg::KIND_PUSH_BACK: lidx = cnt_ext;
      deq_pkg::KIND_POP_BACK,
      deq_pkg::KIND_PEEK_BACK: lidx = cnt_ext - 1'b1;
      deq_pkg::KIND_INSERT_AT: lidx = (pos_ext == cnt_ext) ? pos_ext : cnt_ext - 1'b1;
      default:                 lidx = pos_ext;
    endcase
  end

  // Position to slot: the sum stays below twice the capacity for any legal position.
  assign slot_sum = SumW'(front_q) + SumW'(lidx);
  assign slot     = (slot_sum >= SumW'(CAPACITY)) ? AddrW'(slot_sum - SumW'(CAPACITY))
                                                  : AddrW'(slot_sum);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      deq_pkg::S_IDLE: begin
        if (accept) begin
          case (kind)
            deq_pkg::KIND_INSERT_AT: begin
              if (!is_full && !pos_gt_cnt && (pos_ext != cnt_ext)) begin
                state_d = deq_pkg::S_SHIFT;
              end else begin
                state_d = deq_pkg::S_DONE;
              end
            end
            deq_pkg::KIND_REMOVE_AT: begin
              state_d = pos_ge_cnt ? deq_pkg::S_DONE : deq_pkg::S_RM_CAP;
            end
            default: state_d = deq_pkg::S_DONE;
          endcase
        end
      end
      deq_pkg::S_RM_CAP: begin
        state_d = (moves_q != '0) ? deq_pkg::S_SHIFT : deq_pkg::S_DONE;
      end
      deq_pkg::S_SHIFT: begin
        if (moves_q == CntW'(1)) begin
          state_d = insert_q ? deq_pkg::S_FILL : deq_pkg::S_DONE;
        end
      end
      deq_pkg::S_FILL: state_d = deq_pkg::S_DONE;
      deq_pkg::S_DONE: begin
        if (res_ready_i) begin
          state_d = deq_pkg::S_IDLE;
        end
      end
      default: state_d = deq_pkg::S_IDLE;
    endcase
  end

  // Datapath, store accesses and bookkeeping.
  always_comb begin
    front_d     = front_q;
    count_d     = count_q;
    moves_d     = moves_q;
    rd_slot_d   = rd_slot_q;
    wr_slot_d   = wr_slot_q;
    val_d       = val_q;
    res_data_d  = res_data_q;
    from_mem_d  = from_mem_q;
    insert_d    = insert_q;
    status_d    = status_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = slot;
    mem_we_o    = 1'b0;
    mem_waddr_o = slot;
    mem_wdata_o = in_val;
    res_valid_o = 1'b0;

    case (state_q)
      deq_pkg::S_IDLE: begin
        if (accept) begin
          status_d   = deq_pkg::STATUS_OK;
          from_mem_d = 1'b0;
          res_data_d = '0;
          insert_d   = 1'b0;
          val_d      = in_val;
          case (kind)
            deq_pkg::KIND_PUSH_FRONT: begin
              if (is_full) begin
                status_d = deq_pkg::STATUS_FULL;
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = slot_dec(front_q);
                front_d     = slot_dec(front_q);
                count_d     = count_q + 1'b1;
              end
            end
            deq_pkg::KIND_PUSH_BACK: begin
              if (is_full) begin
                status_d = deq_pkg::STATUS_FULL;
              end else begin
                mem_we_o = 1'b1;
                count_d  = count_q + 1'b1;
              end
            end
            deq_pkg::KIND_POP_FRONT,
            deq_pkg::KIND_PEEK_FRONT: begin
              if (is_empty) begin
                status_d = deq_pkg::STATUS_EMPTY;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = front_q;
                from_mem_d  = 1'b1;
                if (kind == deq_pkg::KIND_POP_FRONT) begin
                  front_d = slot_inc(front_q);
                  count_d = count_q - 1'b1;
                end
              end
            end
            deq_pkg::KIND_POP_BACK,
            deq_pkg::KIND_PEEK_BACK: begin
              if (is_empty) begin
                status_d = deq_pkg::STATUS_EMPTY;
              end else begin
                mem_re_o   = 1'b1;
                from_mem_d = 1'b1;
                if (kind == deq_pkg::KIND_POP_BACK) begin
                  count_d = count_q - 1'b1;
                end
              end
            end
            deq_pkg::KIND_INSERT_AT: begin
              if (is_full) begin
                status_d = deq_pkg::STATUS_FULL;
              end else if (pos_gt_cnt) begin
                status_d = deq_pkg::STATUS_BADPOS;
              end else if (pos_ext == cnt_ext) begin
                // Insert at the end is a plain append.
                mem_we_o = 1'b1;
                count_d  = count_q + 1'b1;
              end else begin
                // Start at the rear and move each entry one slot back.
                mem_re_o  = 1'b1;
                rd_slot_d = slot;
                wr_slot_d = slot_inc(slot);
                moves_d   = CntW'(cnt_ext - pos_ext);
                insert_d  = 1'b1;
                count_d   = count_q + 1'b1;
              end
            end
            deq_pkg::KIND_REMOVE_AT: begin
              if (pos_ge_cnt) begin
                status_d = deq_pkg::STATUS_BADPOS;
              end else begin
                mem_re_o  = 1'b1;
                rd_slot_d = slot;
                moves_d   = CntW'(cnt_ext - pos_ext - 1'b1);
                count_d   = count_q - 1'b1;
              end
            end
            deq_pkg::KIND_REPLACE_AT: begin
              if (pos_ge_cnt) begin
                status_d = deq_pkg::STATUS_BADPOS;
              end else begin
                // The read returns the old word while the new one is written.
                mem_re_o   = 1'b1;
                mem_we_o   = 1'b1;
                from_mem_d = 1'b1;
              end
            end
            deq_pkg::KIND_READ_AT: begin
              if (pos_ge_cnt) begin
                status_d = deq_pkg::STATUS_BADPOS;
              end else begin
                mem_re_o   = 1'b1;
                from_mem_d = 1'b1;
              end
            end
            deq_pkg::KIND_CLEAR: begin
              front_d = '0;
              count_d = '0;
            end
            default: begin
            end
          endcase
        end
      end

      // Keep the removed word, then start pulling the entries behind it forward.
      deq_pkg::S_RM_CAP: begin
        res_data_d = widen(mem_rdata_i);
        if (moves_q != '0) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = slot_inc(rd_slot_q);
          wr_slot_d   = rd_slot_q;
          rd_slot_d   = slot_inc(rd_slot_q);
        end
      end

      // One entry moved per cycle: write the word read last cycle, read the next.
      deq_pkg::S_SHIFT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = wr_slot_q;
        mem_wdata_o = mem_rdata_i;
        moves_d     = moves_q - 1'b1;
        if (moves_q > CntW'(1)) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = insert_q ? slot_dec(rd_slot_q) : slot_inc(rd_slot_q);
          wr_slot_d   = rd_slot_q;
          rd_slot_d   = insert_q ? slot_dec(rd_slot_q) : slot_inc(rd_slot_q);
        end
      end

      // The slot freed by the shift receives the inserted word.
      deq_pkg::S_FILL: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = rd_slot_q;
        mem_wdata_o = val_q;
      end

      deq_pkg::S_DONE: begin
        res_valid_o = 1'b1;
      end

      default: begin
      end
    endcase
  end

  // The store read register holds its word until the next read, so it feeds the result.
  assign res_o.data   = from_mem_q ? widen(mem_rdata_i) : res_data_q;
  assign res_o.status = status_q;
  assign res_o.count  = deq_pkg::COUNT_W'(count_q);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= deq_pkg::S_IDLE;
      front_q <= '0;
      count_q <= '0;
      moves_q <= '0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      count_q <= count_d;
      moves_q <= moves_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    rd_slot_q  <= rd_slot_d;
    wr_slot_q  <= wr_slot_d;
    val_q      <= val_d;
    res_data_q <= res_data_d;
    from_mem_q <= from_mem_d;
    insert_q   <= insert_d;
    status_q   <= status_d;
  end

  `IDE_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CntW'(CAPACITY), "count above capacity")
  `IDE_ASSERT_NEVER(a_shift_moves, clk_i, rst_ni, (state_q == deq_pkg::S_SHIFT) && (moves_q == '0), "shift with no entry left to move")
  `IDE_ASSERT_NEVER(a_shift_overlap, clk_i, rst_ni, (state_q == deq_pkg::S_SHIFT) && mem_re_o && (mem_raddr_o == mem_waddr_o), "shift reads the slot it writes")
  `IDE_ASSERT(a_clear, clk_i, rst_ni, accept && (kind == deq_pkg::KIND_CLEAR) |=> (count_q == '0) && (front_q == '0), "clear left entries behind")

endmodule

@@ bench/indexed_deque_engine_core_tb.sv @@
module indexed_deque_engine_core_tb;

  localparam int CAPACITY = deq_pkg::DEFAULT_CAPACITY;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int POS_MAX  = (1 << deq_pkg::POS_W) - 1;

  typedef logic [deq_pkg::KIND_W-1:0] kind_t;
  typedef logic [deq_pkg::POS_W-1:0]  pos_t;

  // Kind codes that the block leaves without effect.
  localparam kind_t KIND_RESERVED_LO = 4'd11;
  localparam kind_t KIND_RESERVED_HI = 4'd15;

  // One row of the directed table; typed rows carry their own expectation.
  typedef struct packed {
    logic [deq_pkg::KIND_W-1:0]   kind;
    logic [deq_pkg::POS_W-1:0]    pos;
    logic [deq_pkg::VALUE_W-1:0]  value;
    logic                         typed;
    logic [deq_pkg::VALUE_W-1:0]  exp_data;
    logic [deq_pkg::STATUS_W-1:0] exp_status;
    logic [deq_pkg::COUNT_W-1:0]  exp_count;
  } op_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  deq_in_if  op_if ();
  deq_out_if res_if ();

  indexed_deque_engine_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (op_if),
    .out_o  (res_if)
  );

  // Shadow copy of the list: circular store, front slot and entry count.
  logic [deq_pkg::VALUE_W-1:0] shadow_store [CAPACITY];
  logic [IDX_W-1:0]            shadow_front;
  logic [deq_pkg::COUNT_W-1:0] shadow_count;

  deq_pkg::deq_result_t pending_results [$];
  op_row_t              directed_rows [26];

  int send_idle_pct;
  int recv_idle_pct;
  int error_count;
  int ops_sent;
  int results_checked;
  int full_hits;

  // Clock: period of 8.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Physical slot of a list position.
  function automatic logic [IDX_W-1:0] slot_at(input int p);
    int s;
    s = (int'(shadow_front) + p) % CAPACITY;
    return s[IDX_W-1:0];
  endfunction

  // Applies one operation to the shadow list and returns the result it gives.
  function automatic deq_pkg::deq_result_t deque_apply(input kind_t kind,
                                                       input pos_t pos,
                                                       input logic [deq_pkg::VALUE_W-1:0] value);
    deq_pkg::deq_result_t r;
    int i;
    r.data   = '0;
    r.status = deq_pkg::STATUS_OK;
    case (kind)
      deq_pkg::KIND_PUSH_FRONT, deq_pkg::KIND_PUSH_BACK: begin
        if (shadow_count == CAPACITY) begin
          r.status = deq_pkg::STATUS_FULL;
        end else if (kind == deq_pkg::KIND_PUSH_FRONT) begin
          shadow_front = shadow_front - 1'b1;
          shadow_store[shadow_front] = value;
          shadow_count++;
        end else begin
          shadow_store[slot_at(int'(shadow_count))] = value;
          shadow_count++;
        end
      end
      deq_pkg::KIND_POP_FRONT, deq_pkg::KIND_PEEK_FRONT: begin
        if (shadow_count == 0) begin
          r.status = deq_pkg::STATUS_EMPTY;
        end else begin
          r.data = shadow_store[shadow_front];
          if (kind == deq_pkg::KIND_POP_FRONT) begin
            shadow_front = shadow_front + 1'b1;
            shadow_count--;
          end
        end
      end
      deq_pkg::KIND_POP_BACK, deq_pkg::KIND_PEEK_BACK: begin
        if (shadow_count == 0) begin
          r.status = deq_pkg::STATUS_EMPTY;
        end else begin
          r.data = shadow_store[slot_at(int'(shadow_count) - 1)];
          if (kind == deq_pkg::KIND_POP_BACK) shadow_count--;
        end
      end
      deq_pkg::KIND_INSERT_AT: begin
        if (shadow_count == CAPACITY) begin
          r.status = deq_pkg::STATUS_FULL;
        end else if (pos > shadow_count) begin
          r.status = deq_pkg::STATUS_BADPOS;
        end else begin
          for (i = int'(shadow_count); i > int'(pos); i--)
            shadow_store[slot_at(i)] = shadow_store[slot_at(i - 1)];
          shadow_store[slot_at(int'(pos))] = value;
          shadow_count++;
        end
      end
      deq_pkg::KIND_REMOVE_AT: begin
        if (pos >= shadow_count) begin
          r.status = deq_pkg::STATUS_BADPOS;
        end else begin
          r.data = shadow_store[slot_at(int'(pos))];
          for (i = int'(pos); i + 1 < int'(shadow_count); i++)
            shadow_store[slot_at(i)] = shadow_store[slot_at(i + 1)];
          shadow_count--;
        end
      end
      deq_pkg::KIND_REPLACE_AT, deq_pkg::KIND_READ_AT: begin
        if (pos >= shadow_count) begin
          r.status = deq_pkg::STATUS_BADPOS;
        end else begin
          r.data = shadow_store[slot_at(int'(pos))];
          if (kind == deq_pkg::KIND_REPLACE_AT) shadow_store[slot_at(int'(pos))] = value;
        end
      end
      deq_pkg::KIND_CLEAR: begin
        shadow_front = '0;
        shadow_count = '0;
      end
      default: ;
    endcase
    r.count = shadow_count;
    return r;
  endfunction

  // Presents one operation, waits for its transfer and records what it should give.
  task automatic send_op(input kind_t kind, input pos_t pos,
                         input logic [deq_pkg::VALUE_W-1:0] value, input logic typed,
                         input deq_pkg::deq_result_t typed_result);
    deq_pkg::deq_result_t r;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      op_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    op_if.valid    <= 1'b1;
    op_if.kind     <= kind;
    op_if.position <= pos;
    op_if.value    <= value;
    do @(posedge clk_i); while (!op_if.ready);
    r = deque_apply(kind, pos, value);
    if (r.status == deq_pkg::STATUS_FULL) full_hits++;
    pending_results.push_back(typed ? typed_result : r);
    ops_sent++;
    @(negedge clk_i);
  endtask

  // Mostly ordinary words, with the signed extremes mixed in.
  function automatic logic [deq_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 19))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Mostly a valid position for the kind, now and then any 9-bit value.
  function automatic pos_t pick_pos(input kind_t kind);
    int lim;
    if ($urandom_range(0, 9) == 0) return pos_t'($urandom_range(0, POS_MAX));
    lim = (kind == deq_pkg::KIND_INSERT_AT) ? int'(shadow_count) :
          (shadow_count == 0) ? 0 : int'(shadow_count) - 1;
    return pos_t'($urandom_range(0, lim));
  endfunction

  // Random operations that drift the fill level towards a moving target.
  task automatic random_ops(input int n);
    kind_t k;
    int target;
    int r;
    target = $urandom_range(0, 48);
    repeat (n) begin
      if ($urandom_range(0, 19) == 0) target = $urandom_range(0, 48);
      r = $urandom_range(0, 99);
      if (r < 4) begin
        k = kind_t'($urandom_range(KIND_RESERVED_LO, KIND_RESERVED_HI));
      end else if (r < 6) begin
        k = deq_pkg::KIND_CLEAR;
      end else if (r < 60) begin
        if (shadow_count < target) begin
          case ($urandom_range(0, 2))
            0:       k = deq_pkg::KIND_PUSH_FRONT;
            1:       k = deq_pkg::KIND_PUSH_BACK;
            default: k = deq_pkg::KIND_INSERT_AT;
          endcase
        end else begin
          case ($urandom_range(0, 2))
            0:       k = deq_pkg::KIND_POP_FRONT;
            1:       k = deq_pkg::KIND_POP_BACK;
            default: k = deq_pkg::KIND_REMOVE_AT;
          endcase
        end
      end else begin
        k = kind_t'($urandom_range(deq_pkg::KIND_PUSH_FRONT, deq_pkg::KIND_READ_AT));
      end
      send_op(k, pick_pos(k), pick_value(), 1'b0, '0);
    end
  endtask

  // Fills the list to capacity, knocks on the full store, takes a few entries
  // back out and clears it.
  task automatic fill_and_drain();
    kind_t k;
    while (shadow_count < CAPACITY) begin
      case ($urandom_range(0, 3))
        0:       k = deq_pkg::KIND_PUSH_FRONT;
        1:       k = deq_pkg::KIND_INSERT_AT;
        default: k = deq_pkg::KIND_PUSH_BACK;
      endcase
      send_op(k, pos_t'($urandom_range(0, shadow_count)), pick_value(), 1'b0, '0);
    end
    send_op(deq_pkg::KIND_PUSH_FRONT, '0, pick_value(), 1'b0, '0);
    send_op(deq_pkg::KIND_PUSH_BACK, '0, pick_value(), 1'b0, '0);
    send_op(deq_pkg::KIND_INSERT_AT, pos_t'(CAPACITY), pick_value(), 1'b0, '0);
    send_op(deq_pkg::KIND_INSERT_AT, pos_t'(POS_MAX), pick_value(), 1'b0, '0);
    send_op(deq_pkg::KIND_INSERT_AT, '0, pick_value(), 1'b0, '0);
    send_op(deq_pkg::KIND_READ_AT, pos_t'(CAPACITY - 1), '0, 1'b0, '0);
    send_op(deq_pkg::KIND_READ_AT, pos_t'(CAPACITY), '0, 1'b0, '0);
    send_op(deq_pkg::KIND_REPLACE_AT, pos_t'($urandom_range(0, CAPACITY - 1)), pick_value(),
            1'b0, '0);
    send_op(deq_pkg::KIND_PEEK_BACK, '0, '0, 1'b0, '0);
    while (shadow_count > CAPACITY - 16) begin
      case ($urandom_range(0, 3))
        0:       k = deq_pkg::KIND_POP_FRONT;
        1:       k = deq_pkg::KIND_POP_BACK;
        2:       k = deq_pkg::KIND_READ_AT;
        default: k = deq_pkg::KIND_REMOVE_AT;
      endcase
      send_op(k, pos_t'($urandom_range(0, int'(shadow_count) - 1)), '0, 1'b0, '0);
    end
    send_op(deq_pkg::KIND_CLEAR, '0, '0, 1'b0, '0);
  endtask

  // The result sink stalls at random, at the rate of the current phase.
  always @(negedge clk_i) begin
    res_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Every result transfer is matched against the oldest pending expectation.
  always @(posedge clk_i) begin
    deq_pkg::deq_result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected: data %h status %0d count %0d",
               res_if.data, res_if.status, res_if.count);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (res_if.data !== want.data) begin
          $error("data mismatch: expected %h, got %h", want.data, res_if.data);
          error_count++;
        end
        if (res_if.status !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, res_if.status);
          error_count++;
        end
        if (res_if.count !== want.count) begin
          $error("count mismatch: expected %0d, got %0d", want.count, res_if.count);
          error_count++;
        end
      end
    end
  end

  // Stimulus: reset, directed table, then random traffic under three idling mixes.
  initial begin
    deq_pkg::deq_result_t typed_result;
    int guard;
    rst_ni         = 1'b0;
    op_if.valid    = 1'b0;
    op_if.kind     = '0;
    op_if.position = '0;
    op_if.value    = '0;
    res_if.ready   = 1'b0;
    send_idle_pct  = 35;
    recv_idle_pct  = 58;
    error_count    = 0;
    ops_sent       = 0;
    results_checked = 0;
    full_hits      = 0;
    shadow_front   = '0;
    shadow_count   = '0;

    directed_rows = '{
      '{deq_pkg::KIND_POP_FRONT,  9'd0,   32'h0000_0000, 1'b1, 32'd0, deq_pkg::STATUS_EMPTY,  9'd0},
      '{deq_pkg::KIND_POP_BACK,   9'd0,   32'h0000_0000, 1'b1, 32'd0, deq_pkg::STATUS_EMPTY,  9'd0},
      '{deq_pkg::KIND_PEEK_FRONT, 9'd0,   32'h0000_0000, 1'b1, 32'd0, deq_pkg::STATUS_EMPTY,  9'd0},
      '{deq_pkg::KIND_PEEK_BACK,  9'd0,   32'h0000_0000, 1'b1, 32'd0, deq_pkg::STATUS_EMPTY,  9'd0},
      '{deq_pkg::KIND_REMOVE_AT,  9'd0,   32'h0000_0000, 1'b1, 32'd0, deq_pkg::STATUS_BADPOS, 9'd0},
      '{deq_pkg::KIND_REPLACE_AT, 9'd0,   32'h0000_0005, 1'b1, 32'd0, deq_pkg::STATUS_BADPOS, 9'd0},
      '{deq_pkg::KIND_READ_AT,    9'd511, 32'h0000_0000, 1'b1, 32'd0, deq_pkg::STATUS_BADPOS, 9'd0},
      '{deq_pkg::KIND_INSERT_AT,  9'd1,   32'h0000_0007, 1'b1, 32'd0, deq_pkg::STATUS_BADPOS, 9'd0},
      '{KIND_RESERVED_LO,         9'd3,   32'hFFFF_FFFF, 1'b1, 32'd0, deq_pkg::STATUS_OK,     9'd0},
      '{KIND_RESERVED_HI,         9'd511, 32'h1234_5678, 1'b1, 32'd0, deq_pkg::STATUS_OK,     9'd0},
      '{deq_pkg::KIND_PUSH_BACK,  9'd0,   32'h7FFF_FFFF, 1'b1, 32'd0, deq_pkg::STATUS_OK,     9'd1},
      '{deq_pkg::KIND_PUSH_FRONT, 9'd0,   32'h8000_0000, 1'b1, 32'd0, deq_pkg::STATUS_OK,     9'd2},
      '{deq_pkg::KIND_INSERT_AT,  9'd2,   32'hFFFF_FFFF, 1'b1, 32'd0, deq_pkg::STATUS_OK,     9'd3},
      '{deq_pkg::KIND_INSERT_AT,  9'd0,   32'h0000_0000, 1'b1, 32'd0, deq_pkg::STATUS_OK,     9'd4},
      '{deq_pkg::KIND_INSERT_AT,  9'd2,   32'h5A5A_5A5A, 1'b1, 32'd0, deq_pkg::STATUS_OK,     9'd5},
      '{deq_pkg::KIND_PEEK_FRONT, 9'd0,   32'h0000_0000, 1'b0, 32'd0, deq_pkg::STATUS_OK,     9'd0},
      '{deq_pkg::KIND_PEEK_BACK,  9'd0,   32'h0000_0000, 1'b0, 32'd0, deq_pkg::STATUS_OK,     9'd0},
      '{deq_pkg::KIND_READ_AT,    9'd1,   32'h0000_0000, 1'b0, 32'd0, deq_pkg::STATUS_OK,     9'd0},
      '{deq_pkg::KIND_REPLACE_AT, 9'd4,   32'h1234_5678, 1'b0, 32'd0, deq_pkg::STATUS_OK,     9'd0},
      '{deq_pkg::KIND_REMOVE_AT,  9'd1,   32'h0000_0000, 1'b0, 32'd0, deq_pkg::STATUS_OK,     9'd0},
      '{deq_pkg::KIND_READ_AT,    9'd256, 32'h0000_0000, 1'b1, 32'd0, deq_pkg::STATUS_BADPOS, 9'd4},
      '{deq_pkg::KIND_REMOVE_AT,  9'd4,   32'h0000_0000, 1'b1, 32'd0, deq_pkg::STATUS_BADPOS, 9'd4},
      '{deq_pkg::KIND_POP_FRONT,  9'd0,   32'h0000_0000, 1'b0, 32'd0, deq_pkg::STATUS_OK,     9'd0},
      '{deq_pkg::KIND_POP_BACK,   9'd0,   32'h0000_0000, 1'b0, 32'd0, deq_pkg::STATUS_OK,     9'd0},
      '{deq_pkg::KIND_CLEAR,      9'd0,   32'h0000_0000, 1'b1, 32'd0, deq_pkg::STATUS_OK,     9'd0},
      '{deq_pkg::KIND_PEEK_BACK,  9'd0,   32'h0000_0000, 1'b1, 32'd0, deq_pkg::STATUS_EMPTY,  9'd0}
    };

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table.
    foreach (directed_rows[i]) begin
      typed_result.data   = directed_rows[i].exp_data;
      typed_result.status = deq_pkg::deq_status_e'(directed_rows[i].exp_status);
      typed_result.count  = directed_rows[i].exp_count;
      send_op(directed_rows[i].kind, directed_rows[i].pos, directed_rows[i].value,
              directed_rows[i].typed, typed_result);
    end

    // Sink slower than the sender, with one pass through a full store.
    random_ops(20);
    fill_and_drain();

    // Sender slower than the sink.
    send_idle_pct = 58;
    recv_idle_pct = 35;
    random_ops(70);

    // Back to back transfers on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_ops(70);
    op_if.valid <= 1'b0;

    // Drain the remaining results, then allow for the longest shift.
    guard = 0;
    while (pending_results.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (CAPACITY + 40) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      error_count++;
    end

    $display("Sent %0d operations (directed table, random mix under three idling patterns,",
             ops_sent);
    $display("one fill to capacity with %0d full rejections); %0d results compared.",
             full_hits, results_checked);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #20000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/deq_pkg.sv
sv/deq_if.sv
sv/deq_mem.sv
sv/deq_out_reg.sv
sv/deq_ctrl.sv
sv/indexed_deque_engine_core.sv
bench/indexed_deque_engine_core_tb.sv
